// ----- src/solarize_pixel_map_assert.svh -----
// Assertion macros for the solarize pixel map
`ifndef SOLARIZE_PIXEL_MAP_ASSERT_SVH
`define SOLARIZE_PIXEL_MAP_ASSERT_SVH

// same-cycle implication
`define SOLPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SOLPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/solpm_pkg.sv -----
// Shared types and constants of the solarize pixel map
`default_nettype none
package solpm_pkg;

    localparam int LANE_DEPTH = 16;
    localparam int HEAD_DEPTH = 3;
    localparam int PIPE_DEPTH = HEAD_DEPTH + LANE_DEPTH;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam logic [2:0] CFG_THRESHOLD   = 3'd0;
    localparam logic [2:0] CFG_EDGE_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_INVERT      = 3'd2;
    localparam logic [2:0] CFG_MIX         = 3'd3;
    localparam logic [2:0] CFG_PER_CHANNEL = 3'd4;
    localparam logic [2:0] CFG_LUMA_RED    = 3'd5;
    localparam logic [2:0] CFG_LUMA_GREEN  = 3'd6;
    localparam logic [2:0] CFG_LUMA_BLUE   = 3'd7;

    typedef struct packed {
        logic [15:0] threshold;
        logic [15:0] width;
        logic [16:0] amount;
        logic [16:0] mix;
    } t_lane_cfg;

endpackage
`default_nettype wire

// ----- src/solarize_pixel_map.sv -----
// Solarize pixel map top level: input scaling, luma, three color lanes
//
//  channel | direction | handshake              | payload
//  in      | sink      | i_in_valid / o_in_stall | red, green, blue, alpha
//  out     | source    | o_out_valid / i_out_stall | red, green, blue, alpha
//  cfg     | sink      | i_cfg_we                | i_cfg_index, i_cfg_data
//
// One beat per clock while the output is not stalled; 3 front stages and 16 lane stages,
// the lane stages holding the two-bit-per-stage divider of the smoothstep ramp.
// Synchronous active-low reset clears valids and restores register defaults.
// A stalled output beat freezes the whole pipe; no beat is lost or repeated.
`default_nettype none
module solarize_pixel_map #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [15:0] i_in_red,
    input  wire logic [15:0] i_in_green,
    input  wire logic [15:0] i_in_blue,
    input  wire logic [15:0] i_in_alpha,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [15:0] o_out_red,
    output logic      [15:0] o_out_green,
    output logic      [15:0] o_out_blue,
    output logic      [15:0] o_out_alpha,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [16:0] i_cfg_data
);
    import solpm_pkg::*;

    localparam logic [15:0] MAXV  = 16'((32'd1 << CHANNEL_BITS) - 32'd1);
    localparam logic [16:0] HALF  = {1'b0, MAXV >> 1};
    localparam int          SHIFT = 16 - CHANNEL_BITS;

    logic [15:0] r_threshold, r_width;
    logic [16:0] r_amount, r_mix, r_wr, r_wg, r_wb;
    logic        r_per_channel;

    logic [PIPE_DEPTH-1:0] r_vld;
    logic [15:0] r_alpha [0:PIPE_DEPTH-1];
    logic [15:0] r_v1 [0:2];
    logic [15:0] r_v2 [0:2];
    logic [15:0] r_v3 [0:2];
    logic [16:0] r_x1 [0:2];
    logic [16:0] r_x2 [0:2];
    logic [33:0] r_lp [0:2];
    logic [19:0] r_level [0:2];

    logic        en;
    logic [15:0] vin  [0:2];
    logic [15:0] vsat [0:2];
    logic [16:0] n_x  [0:2];
    logic [35:0] lsum;
    logic [15:0] asat;
    logic [15:0] lane_out [0:2];
    t_lane_cfg   lcfg;

    assign en          = !(r_vld[PIPE_DEPTH-1] && i_out_stall);
    assign o_in_stall  = !en;
    assign o_out_valid = r_vld[PIPE_DEPTH-1];

    assign vin[0] = i_in_red;
    assign vin[1] = i_in_green;
    assign vin[2] = i_in_blue;
    assign asat   = (i_in_alpha > MAXV) ? MAXV : i_in_alpha;

    // x = floor((v * 65536 + MAXV/2) / MAXV) by folding on 2^N - 1
    always_comb begin
        logic [15:0] c;
        logic [16:0] y;
        logic [16:0] q;
        for (int i = 0; i < 3; i++) begin
            vsat[i] = (vin[i] > MAXV) ? MAXV : vin[i];
            c = vsat[i] << SHIFT;
            y = {1'b0, c} + HALF;
            q = 17'd0;
            for (int f = 0; f < 3; f++) begin
                q = q + (y >> CHANNEL_BITS);
                y = (y >> CHANNEL_BITS) + (y & {1'b0, MAXV});
            end
            if (y >= {1'b0, MAXV}) begin
                q = q + 17'd1;
            end
            n_x[i] = {1'b0, c} + q;
        end
    end

    assign lsum = {2'd0, r_lp[0]} + {2'd0, r_lp[1]} + {2'd0, r_lp[2]} + 36'd32768;

    always_comb begin
        lcfg.threshold = r_threshold;
        lcfg.width     = r_width;
        lcfg.amount    = (r_amount > ONE_Q16) ? ONE_Q16 : r_amount;
        lcfg.mix       = (r_mix > ONE_Q16) ? ONE_Q16 : r_mix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold   <= 16'd32768;
            r_width       <= 16'd3277;
            r_amount      <= 17'd65536;
            r_mix         <= 17'd65536;
            r_per_channel <= 1'b1;
            r_wr          <= 17'd13933;
            r_wg          <= 17'd46871;
            r_wb          <= 17'd4732;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_THRESHOLD:   r_threshold   <= i_cfg_data[15:0];
                CFG_EDGE_WIDTH:  r_width       <= i_cfg_data[15:0];
                CFG_INVERT:      r_amount      <= i_cfg_data;
                CFG_MIX:         r_mix         <= i_cfg_data;
                CFG_PER_CHANNEL: r_per_channel <= i_cfg_data[0];
                CFG_LUMA_RED:    r_wr          <= i_cfg_data;
                CFG_LUMA_GREEN:  r_wg          <= i_cfg_data;
                CFG_LUMA_BLUE:   r_wb          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_alpha[0] <= asat;
            for (int j = 1; j < PIPE_DEPTH; j++) begin
                r_alpha[j] <= r_alpha[j-1];
            end
            for (int i = 0; i < 3; i++) begin
                r_v1[i] <= vsat[i];
                r_x1[i] <= n_x[i];
                r_v2[i] <= r_v1[i];
                r_x2[i] <= r_x1[i];
                r_v3[i] <= r_v2[i];
                r_level[i] <= r_per_channel ? {3'd0, r_x2[i]} : lsum[35:16];
            end
            r_lp[0] <= r_wr * r_x1[0];
            r_lp[1] <= r_wg * r_x1[1];
            r_lp[2] <= r_wb * r_x1[2];
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        solpm_lane #(
            .CHANNEL_BITS(CHANNEL_BITS)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_cfg   (lcfg),
            .i_level (r_level[g]),
            .i_v     (r_v3[g]),
            .o_out   (lane_out[g])
        );
    end

    assign o_out_red   = lane_out[0];
    assign o_out_green = lane_out[1];
    assign o_out_blue  = lane_out[2];
    assign o_out_alpha = r_alpha[PIPE_DEPTH-1];

`include "solarize_pixel_map_assert.svh"

    `SOLPM_ASSERT_NEXT(a_enter, i_in_valid && !o_in_stall, r_vld[0], "accepted beat not captured")
    `SOLPM_ASSERT_NEXT(a_freeze, !en, $stable(r_vld), "valid chain moved while stalled")
    `SOLPM_ASSERT_NOW(a_clamp, o_out_valid, o_out_red <= MAXV && o_out_blue <= MAXV, "output above full scale")

endmodule
`default_nettype wire

// ----- src/solpm_lane.sv -----
// One color lane: smoothstep weight, inversion blend, round and clamp
`default_nettype none
module solpm_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  wire logic                i_clk,
    input  wire logic                i_en,
    input  wire solpm_pkg::t_lane_cfg i_cfg,
    input  wire logic [19:0]         i_level,
    input  wire logic [15:0]         i_v,
    output logic      [15:0]         o_out
);
    import solpm_pkg::*;

    localparam logic [15:0] MAXV = 16'((32'd1 << CHANNEL_BITS) - 32'd1);

    logic [16:0] r_rem [0:8];
    logic [15:0] r_q   [0:8];
    logic        r_one [0:8];
    logic        r_nil [0:8];
    logic [15:0] r_v   [1:15];
    logic [33:0] r_t2;
    logic [17:0] r_p;
    logic [33:0] r_pa;
    logic [34:0] r_pb;
    logic [16:0] r_s;
    logic [16:0] r_k;
    logic [32:0] r_km;
    logic signed [34:0] r_ph;
    logic signed [35:0] r_pl;
    logic [15:0] r_out;

    logic signed [21:0] lv, e0, diff;
    logic        ge, below, full, zero;
    logic [16:0] dd;
    logic [16:0] n_rem [1:8];
    logic [15:0] n_q   [1:8];
    logic [16:0] t;
    logic [50:0] ssum;
    logic [34:0] kprod;
    logic signed [17:0] span;
    logic signed [52:0] racc;
    logic [52:0] rround;
    logic [20:0] o_wide;
    logic [15:0] n_out;

    always_comb begin
        lv    = $signed({2'b00, i_level});
        e0    = $signed({6'd0, i_cfg.threshold}) - $signed({6'd0, i_cfg.width});
        diff  = lv - e0;
        dd    = {i_cfg.width, 1'b0};
        zero  = (i_cfg.width == 16'd0);
        ge    = (i_level >= {4'd0, i_cfg.threshold});
        below = (lv <= e0);
        full  = (diff >= $signed({5'd0, dd}));
    end

    // long division, two quotient bits per stage; dividend low bits are the width
    always_comb begin
        logic [17:0] a;
        logic [17:0] b;
        for (int j = 1; j <= 8; j++) begin
            a = {r_rem[j-1], i_cfg.width[17-2*j]};
            n_q[j] = r_q[j-1];
            if (a >= {1'b0, dd}) begin
                a = a - {1'b0, dd};
                n_q[j][17-2*j] = 1'b1;
            end
            b = {a[16:0], i_cfg.width[16-2*j]};
            if (b >= {1'b0, dd}) begin
                b = b - {1'b0, dd};
                n_q[j][16-2*j] = 1'b1;
            end
            n_rem[j] = b[16:0];
        end
    end

    always_comb begin
        t      = r_one[8] ? ONE_Q16 : (r_nil[8] ? 17'd0 : {1'b0, r_q[8]});
        ssum   = {r_pa, 17'd0} + {16'd0, r_pb} + 51'h0_8000_0000;
        kprod  = {1'b0, 34'(r_s * i_cfg.amount)} + 35'd32768;
        span   = $signed({2'b00, MAXV}) - $signed({1'b0, r_v[14], 1'b0});
        racc   = $signed({5'd0, r_v[15], 32'd0}) + ($signed(53'(r_ph)) <<< 17)
                 + $signed(53'(r_pl));
        rround = racc[52] ? 53'd0 : ($unsigned(racc) + 53'h0_8000_0000);
        o_wide = rround[52:32];
        n_out  = (o_wide > {5'd0, MAXV}) ? MAXV : o_wide[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= diff[16:0];
            r_q[0]   <= 16'd0;
            r_one[0] <= zero ? ge : (!below && full);
            r_nil[0] <= zero ? !ge : below;
            r_v[1]   <= i_v;
            for (int j = 1; j <= 8; j++) begin
                r_rem[j] <= n_rem[j];
                r_q[j]   <= n_q[j];
                r_one[j] <= r_one[j-1];
                r_nil[j] <= r_nil[j-1];
            end
            for (int j = 2; j <= 15; j++) begin
                r_v[j] <= r_v[j-1];
            end
            r_t2  <= 34'(t * t);
            r_p   <= 18'd196608 - {t, 1'b0};
            r_pa  <= 34'(r_t2[32:17] * r_p);
            r_pb  <= 35'(r_t2[16:0] * r_p);
            r_s   <= ssum[48:32];
            r_k   <= kprod[32:16];
            r_km  <= 33'(r_k * i_cfg.mix);
            r_ph  <= 35'(span * $signed({1'b0, r_km[32:17]}));
            r_pl  <= 36'(span * $signed({1'b0, r_km[16:0]}));
            r_out <= n_out;
        end
    end

    assign o_out = r_out;

endmodule
`default_nettype wire

// ----- sim/solarize_pixel_map_tb.sv -----
// Testbench for the solarize pixel map: queued random and directed pixels, scoreboard check
`timescale 1ns / 100ps
`default_nettype none
module solarize_pixel_map_tb;
    import solpm_pkg::*;

    localparam int  IDLE_LIMIT = 20000;
    localparam longint MAXV = 65535;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_pixel;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [15:0] i_in_red = '0, i_in_green = '0, i_in_blue = '0, i_in_alpha = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_out_red, o_out_green, o_out_blue, o_out_alpha;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [16:0] i_cfg_data = '0;

    solarize_pixel_map u_top (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // local copy of the block's registers
    longint thr_q, wid_q, amt_q, mix_q, lw_r, lw_g, lw_b;
    bit     per_chan;

    t_pixel pixel_queue[$];
    t_pixel solarized_queue[$];
    int     send_idle_pct = 0, recv_idle_pct = 0;
    bit     hold_off = 1'b0;
    int     hold_cycles = 0;
    int     fail_count = 0;
    int     quiet_cycles = 0;
    bit     in_fire = 1'b0;

    function automatic longint sat_one(longint v);
        return v > 65536 ? 65536 : v;
    endfunction

    function automatic longint ramp_weight(longint level);
        longint e0, t, s;
        if (wid_q == 0) begin
            s = level >= thr_q ? 65536 : 0;
        end else begin
            e0 = thr_q - wid_q;
            if (level <= e0) begin
                s = 0;
            end else begin
                t = ((level - e0) * 65536 + wid_q) / (2 * wid_q);
                if (t > 65536) t = 65536;
                s = (t * t * (196608 - 2 * t) + 64'sd2147483648) >>> 32;
            end
        end
        return (s * sat_one(amt_q) + 32768) >>> 16;
    endfunction

    function automatic logic [15:0] blend_chan(longint v, longint k);
        longint r, o;
        r = (v <<< 32) + (MAXV - 2 * v) * (k * sat_one(mix_q));
        if (r < 0) r = 0;
        o = (r + 64'sd2147483648) >>> 32;
        if (o > MAXV) o = MAXV;
        return o[15:0];
    endfunction

    function automatic t_pixel solarize(t_pixel p);
        longint v[3], x[3], k[3], luma;
        t_pixel q;
        v[0] = p.red; v[1] = p.green; v[2] = p.blue;
        for (int i = 0; i < 3; i++) x[i] = (v[i] * 65536 + MAXV / 2) / MAXV;
        if (per_chan) begin
            for (int i = 0; i < 3; i++) k[i] = ramp_weight(x[i]);
        end else begin
            luma = (lw_r * x[0] + lw_g * x[1] + lw_b * x[2] + 32768) >>> 16;
            for (int i = 0; i < 3; i++) k[i] = ramp_weight(luma);
        end
        q.red = blend_chan(v[0], k[0]);
        q.green = blend_chan(v[1], k[1]);
        q.blue = blend_chan(v[2], k[2]);
        q.alpha = p.alpha;
        return q;
    endfunction

    task automatic queue_pixel(t_pixel p);
        pixel_queue = {pixel_queue, p};
    endtask

    always @(posedge i_clk) begin
        in_fire <= i_in_valid && !o_in_stall;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_fire) begin
                if (pixel_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    t_pixel p;
                    p = pixel_queue.pop_front();
                    solarized_queue = {solarized_queue, solarize(p)};
                    {i_in_red, i_in_green, i_in_blue, i_in_alpha} <= p;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            if (hold_off) begin
                i_out_stall <= 1'b1;
                hold_cycles <= hold_cycles + 1;
            end else begin
                i_out_stall <= $urandom_range(99) < recv_idle_pct;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            t_pixel e;
            if (solarized_queue.size() == 0) begin
                $error("beat with nothing expected");
                fail_count++;
            end else begin
                e = solarized_queue.pop_front();
                if (o_out_red !== e.red) begin
                    $error("out_red exp %0d got %0d", e.red, o_out_red); fail_count++;
                end
                if (o_out_green !== e.green) begin
                    $error("out_green exp %0d got %0d", e.green, o_out_green); fail_count++;
                end
                if (o_out_blue !== e.blue) begin
                    $error("out_blue exp %0d got %0d", e.blue, o_out_blue); fail_count++;
                end
                if (o_out_alpha !== e.alpha) begin
                    $error("out_alpha exp %0d got %0d", e.alpha, o_out_alpha); fail_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || hold_off
                || (pixel_queue.size() == 0 && solarized_queue.size() == 0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("solarize_pixel_map_tb failed");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, longint val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val[16:0];
        case (idx)
            CFG_THRESHOLD:   thr_q = val & 16'hFFFF;
            CFG_EDGE_WIDTH:  wid_q = val & 16'hFFFF;
            CFG_INVERT:      amt_q = val & 17'h1FFFF;
            CFG_MIX:         mix_q = val & 17'h1FFFF;
            CFG_PER_CHANNEL: per_chan = val[0];
            CFG_LUMA_RED:    lw_r = val & 17'h1FFFF;
            CFG_LUMA_GREEN:  lw_g = val & 17'h1FFFF;
            default:         lw_b = val & 17'h1FFFF;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pixel_queue.size() > 0 || solarized_queue.size() > 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_level();
        case ($urandom_range(5))
            0: return 16'(0);
            1: return 16'hFFFF;
            2: return 16'(thr_q + $urandom_range(2 * wid_q + 2) - wid_q - 1);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_random(int n);
        t_pixel p;
        repeat (n) begin
            p.red = rand_level(); p.green = rand_level();
            p.blue = rand_level(); p.alpha = 16'($urandom);
            queue_pixel(p);
        end
    endtask

    task automatic random_config();
        write_reg(CFG_THRESHOLD, $urandom_range(65535));
        write_reg(CFG_EDGE_WIDTH, $urandom_range(3) == 0 ? 0 : $urandom_range(32768));
        write_reg(CFG_INVERT, $urandom_range(3) == 0 ? 65536 : $urandom_range(131071));
        write_reg(CFG_MIX, $urandom_range(3) == 0 ? 65536 : $urandom_range(131071));
        write_reg(CFG_PER_CHANNEL, $urandom_range(1));
        write_reg(CFG_LUMA_RED, $urandom_range(131071));
        write_reg(CFG_LUMA_GREEN, $urandom_range(65536));
        write_reg(CFG_LUMA_BLUE, $urandom_range(65536));
    endtask

    initial begin
        thr_q = 32768; wid_q = 3277; amt_q = 65536; mix_q = 65536; per_chan = 1'b1;
        lw_r = 13933; lw_g = 46871; lw_b = 4732;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes at reset settings
        queue_pixel('{16'h0000, 16'hFFFF, 16'h8000, 16'h0000});
        queue_pixel('{16'hFFFF, 16'h0000, 16'h7FFF, 16'hFFFF});
        queue_pixel('{16'h7333, 16'h8CCC, 16'h8001, 16'h5555});
        queue_pixel('{16'hAAAA, 16'h5555, 16'h0001, 16'hAAAA});
        drain();
        // zero width step, luma mode, above-full amount and mix
        write_reg(CFG_EDGE_WIDTH, 0);
        write_reg(CFG_INVERT, 131071);
        write_reg(CFG_MIX, 131071);
        queue_pixel('{16'h7FFF, 16'h8000, 16'h8001, 16'h1234});
        drain();
        write_reg(CFG_PER_CHANNEL, 0);
        write_reg(CFG_LUMA_RED, 65536);
        write_reg(CFG_LUMA_GREEN, 65536);
        write_reg(CFG_LUMA_BLUE, 65536);
        write_reg(CFG_EDGE_WIDTH, 32768);
        write_reg(CFG_THRESHOLD, 65535);
        queue_pixel('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
        queue_pixel('{16'h4000, 16'h0000, 16'h0000, 16'h0000});
        drain();
        write_reg(CFG_THRESHOLD, 0);
        write_reg(CFG_INVERT, 0);
        write_reg(CFG_MIX, 0);
        queue_pixel('{16'h0000, 16'h0000, 16'h0000, 16'h0000});
        queue_pixel('{16'hFFFF, 16'h1000, 16'h2000, 16'h3000});
        drain();

        // random phases
        for (int ph = 0; ph < 9; ph++) begin
            random_config();
            if (ph < 3) begin send_idle_pct = 8;  recv_idle_pct = 56; end
            else if (ph < 6) begin send_idle_pct = 56; recv_idle_pct = 8; end
            else begin send_idle_pct = 0; recv_idle_pct = 0; end
            queue_random(44);
            if (ph == 7) begin
                @(negedge i_clk);
                hold_off = 1'b1;
                @(posedge i_clk);
                while (hold_cycles < 60) @(posedge i_clk);
                hold_off = 1'b0;
            end
            drain();
        end

        if (fail_count == 0)
            $display("solarize_pixel_map_tb passed");
        else
            $display("solarize_pixel_map_tb failed");
        $finish;
    end
endmodule
`default_nettype wire
